// File: src/cct_pkg.sv
// package for the cable continuity test sequencer
// shared constants, register indexes and request/result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

   localparam int INPUT_COUNT  = 8;
   localparam int OUTPUT_COUNT = 2;

   // current output runs from 0 up to OUTPUT_COUNT inclusive
   localparam int OUT_IDX_W = $clog2(OUTPUT_COUNT + 1);

   localparam int TIME_W  = 32;
   localparam int CSR_W   = 16;
   localparam int CNT_W   = 4;
   localparam int MASK_W  = 8;
   localparam int INDEX_W = 3;

   // configuration register indexes
   localparam logic [1:0] CSR_SETTLE_TIME     = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_COUNT    = 2'd2;

   localparam logic [CSR_W-1:0] SETTLE_TIME_RESET     = 16'd300;
   localparam logic [CSR_W-1:0] SAMPLE_INTERVAL_RESET = 16'd240;
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET    = 4'd5;

   // request mode codes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef struct packed {
      logic [CSR_W-1:0] settle_time;
      logic [CSR_W-1:0] sample_interval;
      logic [CNT_W-1:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic              mode;
      logic [TIME_W-1:0] now;
      logic              output_readback;
      logic [MASK_W-1:0] input_levels;
      logic              shield_level;
   } req_type;

   typedef struct packed {
      logic               drive_enable;
      logic [INDEX_W-1:0] drive_index;
      logic               restore_low;
      logic               busy_res;
      logic               done_res;
      logic               shielded;
      logic [MASK_W-1:0]  readback_bits;
      logic [MASK_W-1:0]  first_input_mask;
      logic [MASK_W-1:0]  second_input_mask;
      logic               wiring;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/cct_engine.sv
// test sequencing state and single-pass step logic
// depends on cct_pkg
`timescale 1ns / 1ps
`default_nettype none

module cct_engine
   import cct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    step_fire,
   input  wire req_type step_req,
   output rsp_type      step_rsp
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SETTLE = 2'd1;
   localparam logic [1:0] PH_SAMPLE = 2'd2;
   localparam logic [1:0] PH_SHIELD = 2'd3;

   logic                 running_ff, running_in;
   logic [1:0]           phase_ff, phase_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;
   logic [OUT_IDX_W-1:0] current_output_ff, current_output_in;
   logic [CNT_W-1:0]     sample_number_ff, sample_number_in;
   logic [CNT_W-1:0]     input_high_counts_ff [INPUT_COUNT];
   logic [CNT_W-1:0]     input_high_counts_in [INPUT_COUNT];
   logic [CNT_W-1:0]     shield_count_ff, shield_count_in;
   logic [MASK_W-1:0]    readback_mask_ff, readback_mask_in;
   logic [MASK_W-1:0]    mask0_ff, mask0_in;
   logic [MASK_W-1:0]    mask1_ff, mask1_in;

   logic [TIME_W-1:0]    time_diff;
   logic                 reached;
   logic [TIME_W-1:0]    now_plus1;
   logic [TIME_W-1:0]    dl_settle;
   logic [TIME_W-1:0]    dl_settle_next;
   logic [TIME_W-1:0]    dl_interval;
   logic [CNT_W-1:0]     counts_inc [INPUT_COUNT];
   logic [MASK_W-1:0]    vote;
   logic [CNT_W-1:0]     half_count;
   logic [CNT_W-1:0]     sample_next;
   logic [OUT_IDX_W-1:0] output_next;
   logic [CNT_W-1:0]     shield_next;
   logic                 done;
   logic                 enable;

   // wrapping time compare: reached when now - deadline is not negative
   assign time_diff      = step_req.now - deadline_ff;
   assign reached        = ~time_diff[TIME_W-1];
   assign now_plus1      = step_req.now + 32'd1;
   assign dl_settle      = step_req.now + TIME_W'(cfg.settle_time);
   assign dl_settle_next = now_plus1 + TIME_W'(cfg.settle_time);
   assign dl_interval    = step_req.now + TIME_W'(cfg.sample_interval);
   assign half_count     = cfg.sample_count >> 1;
   assign sample_next    = sample_number_ff + 4'd1;
   assign output_next    = current_output_ff + OUT_IDX_W'(1);
   assign shield_next    = shield_count_ff + CNT_W'(step_req.shield_level);

   always_comb begin
      vote = '0;
      for (int i = 0; i < INPUT_COUNT; i++) begin
         counts_inc[i] = input_high_counts_ff[i] + CNT_W'(step_req.input_levels[i]);
         vote[i]       = (counts_inc[i] > half_count);
      end
   end

   always_comb begin
      running_in        = running_ff;
      phase_in          = phase_ff;
      deadline_in       = deadline_ff;
      current_output_in = current_output_ff;
      sample_number_in  = sample_number_ff;
      input_high_counts_in = input_high_counts_ff;
      shield_count_in   = shield_count_ff;
      readback_mask_in  = readback_mask_ff;
      mask0_in          = mask0_ff;
      mask1_in          = mask1_ff;
      done              = 1'b0;

      if (step_req.mode == MODE_START) begin
         running_in        = 1'b1;
         phase_in          = PH_SETTLE;
         deadline_in       = dl_settle;
         current_output_in = '0;
         sample_number_in  = '0;
         for (int i = 0; i < INPUT_COUNT; i++) input_high_counts_in[i] = '0;
         shield_count_in   = '0;
         readback_mask_in  = '0;
         mask0_in          = '0;
         mask1_in          = '0;
      end else if (running_ff && reached) begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_SETTLE: begin
               readback_mask_in = readback_mask_ff
                                | (MASK_W'(step_req.output_readback) << current_output_ff);
               phase_in         = PH_SAMPLE;
               deadline_in      = dl_interval;
            end
            PH_SAMPLE: begin
               input_high_counts_in = counts_inc;
               sample_number_in     = sample_next;
               if (sample_next < cfg.sample_count) begin
                  deadline_in = dl_interval;
               end else begin
                  // only the first two outputs keep a connection mask
                  if (current_output_ff == OUT_IDX_W'(0)) mask0_in = mask0_ff | vote;
                  if (current_output_ff == OUT_IDX_W'(1)) mask1_in = mask1_ff | vote;
                  current_output_in = output_next;
                  sample_number_in  = '0;
                  if (output_next < OUT_IDX_W'(OUTPUT_COUNT)) begin
                     for (int i = 0; i < INPUT_COUNT; i++) input_high_counts_in[i] = '0;
                     deadline_in = dl_settle_next;
                     phase_in    = PH_SETTLE;
                  end else begin
                     shield_count_in = '0;
                     deadline_in     = now_plus1;
                     phase_in        = PH_SHIELD;
                  end
               end
            end
            PH_SHIELD: begin
               shield_count_in  = shield_next;
               sample_number_in = sample_next;
               if (sample_next < cfg.sample_count) begin
                  deadline_in = now_plus1;
               end else begin
                  done       = 1'b1;
                  running_in = 1'b0;
                  phase_in   = PH_IDLE;
               end
            end
         endcase
      end
   end

   assign enable = running_in && (phase_in == PH_SETTLE || phase_in == PH_SAMPLE);

   always_comb begin
      step_rsp                   = '0;
      step_rsp.drive_enable      = enable;
      step_rsp.drive_index       = enable ? INDEX_W'(current_output_in) : '0;
      step_rsp.restore_low       = done;
      step_rsp.busy_res          = running_in;
      step_rsp.done_res          = done;
      if (done) begin
         step_rsp.shielded          = (shield_count_in > half_count);
         step_rsp.readback_bits     = readback_mask_in;
         step_rsp.first_input_mask  = mask0_in;
         step_rsp.second_input_mask = mask1_in;
         step_rsp.wiring            = !(mask0_in[0] && mask1_in[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff        <= 1'b0;
         phase_ff          <= PH_IDLE;
         deadline_ff       <= '0;
         current_output_ff <= '0;
         sample_number_ff  <= '0;
         for (int i = 0; i < INPUT_COUNT; i++) input_high_counts_ff[i] <= '0;
         shield_count_ff   <= '0;
         readback_mask_ff  <= '0;
         mask0_ff          <= '0;
         mask1_ff          <= '0;
      end else if (step_fire) begin
         running_ff        <= running_in;
         phase_ff          <= phase_in;
         deadline_ff       <= deadline_in;
         current_output_ff <= current_output_in;
         sample_number_ff  <= sample_number_in;
         input_high_counts_ff <= input_high_counts_in;
         shield_count_ff   <= shield_count_in;
         readback_mask_ff  <= readback_mask_in;
         mask0_ff          <= mask0_in;
         mask1_ff          <= mask1_in;
      end
   end

   a_idle_when_stopped: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> phase_ff == PH_IDLE)
      else $error("phase not idle while test stopped");

   a_drive_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SETTLE || phase_ff == PH_SAMPLE)
         |-> current_output_ff < OUT_IDX_W'(OUTPUT_COUNT))
      else $error("driven output beyond output count");

   a_shield_after_outputs: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SHIELD |-> current_output_ff == OUT_IDX_W'(OUTPUT_COUNT))
      else $error("shield phase before all outputs done");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_req.mode == MODE_START
         |=> running_ff && phase_ff == PH_SETTLE && current_output_ff == '0)
      else $error("start request did not restart the test");

endmodule

`default_nettype wire

// File: src/cable_continuity_test_sequencer.sv
// path: an accepted request is held in the request register, and its result is then written to the result register
// throughput: one request per cycle while the result side does not stall; the deadline subtract and compare plus the
// next-deadline adders sit between the request register and the result register
// reset: synchronous active high; clears the test state and both handshakes and
// loads the register defaults (settle 300, interval 240, count 5)
// top level: request and result registers, configuration registers; uses cct_pkg, cct_engine
`timescale 1ns / 1ps
`default_nettype none

module cable_continuity_test_sequencer
   import cct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic [TIME_W-1:0] req_now,
   input  wire logic              req_output_readback,
   input  wire logic [MASK_W-1:0] req_input_levels,
   input  wire logic              req_shield_level,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_drive_enable,
   output logic [INDEX_W-1:0]     rsp_drive_index,
   output logic                   rsp_restore_low,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_shielded,
   output logic [MASK_W-1:0]      rsp_readback_bits,
   output logic [MASK_W-1:0]      rsp_first_input_mask,
   output logic [MASK_W-1:0]      rsp_second_input_mask,
   output logic                   rsp_wiring,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    step_fire;
   logic    req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_time     <= SETTLE_TIME_RESET;
         cfg_ff.sample_interval <= SAMPLE_INTERVAL_RESET;
         cfg_ff.sample_count    <= SAMPLE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SETTLE_TIME:     cfg_ff.settle_time     <= csr_wdata;
            CSR_SAMPLE_INTERVAL: cfg_ff.sample_interval <= csr_wdata;
            CSR_SAMPLE_COUNT:    cfg_ff.sample_count    <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // the held request moves on whenever the result register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_fire = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take ? 1'b1 : (req_valid_ff && !advance);
   assign rsp_valid_in = step_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.mode            <= req_mode;
         req_ff.now             <= req_now;
         req_ff.output_readback <= req_output_readback;
         req_ff.input_levels    <= req_input_levels;
         req_ff.shield_level    <= req_shield_level;
      end
      if (step_fire) rsp_ff <= step_rsp;
   end

   cct_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .step_fire(step_fire),
      .step_req (req_ff),
      .step_rsp (step_rsp)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drive_enable      = rsp_ff.drive_enable;
   assign rsp_drive_index       = rsp_ff.drive_index;
   assign rsp_restore_low       = rsp_ff.restore_low;
   assign rsp_busy_res          = rsp_ff.busy_res;
   assign rsp_done_res          = rsp_ff.done_res;
   assign rsp_shielded          = rsp_ff.shielded;
   assign rsp_readback_bits     = rsp_ff.readback_bits;
   assign rsp_first_input_mask  = rsp_ff.first_input_mask;
   assign rsp_second_input_mask = rsp_ff.second_input_mask;
   assign rsp_wiring            = rsp_ff.wiring;

endmodule

`default_nettype wire
